FILE: hw/rtl/bse_pkg.sv
// ----------------------------------------------------------------------------
// Burning Ship escape-time package
// Shared word types, queue entry type and sizing constants.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int FRAC_BITS     = 26;
  localparam int COUNT_W       = 12;
  localparam int PIXEL_W       = 10;
  localparam int POINT_W       = 32;
  localparam int Z_W           = 33;
  localparam int MAG_W         = 27;
  localparam int PROD_W        = 2 * MAG_W;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam logic [COUNT_W-1:0] MAX_ITER_RESET = COUNT_W'(30);

  typedef struct packed {
    logic signed [POINT_W-1:0] point_real;
    logic signed [POINT_W-1:0] point_imag;
    logic [PIXEL_W-1:0]        pixel_col;
    logic [PIXEL_W-1:0]        pixel_row;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] iteration_count;
    logic               inside_set;
    logic [PIXEL_W-1:0] out_col;
    logic [PIXEL_W-1:0] out_row;
  } out_word_t;

  typedef struct packed {
    in_word_t word;
    logic     zero_limit;
  } queue_entry_t;

  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_head_t;

endpackage

FILE: hw/rtl/bse_front.sv
// ----------------------------------------------------------------------------
// Burning Ship front end
// Accepts input words, marks those that need no iteration, and holds them
// in a short queue until the iteration engine takes them.
// ----------------------------------------------------------------------------
module bse_front import bse_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_word_t           in_data,
  input  logic [COUNT_W-1:0] max_iterations,
  output queue_head_t        head,
  input  logic               pop
);

  queue_entry_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]       count_r, count_nxt;
  logic                    push;
  logic                    do_pop;

  assign busy   = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r].word       <= in_data;
      mem_r[wr_ptr_r].zero_limit <= (max_iterations == '0);
    end
  end

endmodule

FILE: hw/rtl/bse_engine.sv
// ----------------------------------------------------------------------------
// Burning Ship iteration engine
// Runs the escape-time iteration for one point at a time; each iteration
// forms magnitudes and products first, then does the escape test and update.
// ----------------------------------------------------------------------------
module bse_engine import bse_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  queue_head_t        head,
  output logic               pop,
  input  logic [COUNT_W-1:0] max_iterations,
  output logic               out_valid,
  output out_word_t          out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ADD
  } state_t;

  state_t                     state_r;
  logic signed [Z_W-1:0]      x_r, y_r;
  logic signed [POINT_W-1:0]  c_re_r, c_im_r;
  logic [PIXEL_W-1:0]         col_r, row_r;
  logic [COUNT_W-1:0]         count_r;
  logic [PROD_W-1:0]          xsq_r, ysq_r, xy_r;
  logic                       big_r;
  logic                       out_valid_r;
  out_word_t                  out_data_r;

  logic [Z_W-1:0]             ax, ay;
  logic                       big;
  logic [PROD_W:0]            mag_sum;
  logic                       escaped;
  logic signed [Z_W-1:0]      x_new, y_new;
  logic [COUNT_W-1:0]         count_inc;

  always_comb begin
    ax  = x_r[Z_W-1] ? Z_W'(-x_r) : Z_W'(x_r);
    ay  = y_r[Z_W-1] ? Z_W'(-y_r) : Z_W'(y_r);
    big = (|ax[Z_W-1:MAG_W]) || (|ay[Z_W-1:MAG_W]);
  end

  always_comb begin
    mag_sum   = {1'b0, xsq_r} + {1'b0, ysq_r};
    escaped   = big_r || mag_sum[PROD_W];
    x_new     = $signed({{(Z_W-(PROD_W-FRAC_BITS)){1'b0}}, xsq_r[PROD_W-1:FRAC_BITS]})
              - $signed({{(Z_W-(PROD_W-FRAC_BITS)){1'b0}}, ysq_r[PROD_W-1:FRAC_BITS]})
              + $signed({{(Z_W-POINT_W){c_re_r[POINT_W-1]}}, c_re_r});
    y_new     = $signed({{(Z_W-(PROD_W-FRAC_BITS+1)){1'b0}}, xy_r[PROD_W-1:FRAC_BITS-1]})
              + $signed({{(Z_W-POINT_W){c_im_r[POINT_W-1]}}, c_im_r});
    count_inc = count_r + 1'b1;
  end

  assign pop       = (state_r == S_IDLE) && head.valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (head.valid) begin
            x_r     <= '0;
            y_r     <= '0;
            count_r <= '0;
            c_re_r  <= head.entry.word.point_real;
            c_im_r  <= head.entry.word.point_imag;
            col_r   <= head.entry.word.pixel_col;
            row_r   <= head.entry.word.pixel_row;
            if (head.entry.zero_limit) begin
              out_valid_r                <= 1'b1;
              out_data_r.iteration_count <= '0;
              out_data_r.inside_set      <= 1'b1;
              out_data_r.out_col         <= head.entry.word.pixel_col;
              out_data_r.out_row         <= head.entry.word.pixel_row;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          big_r   <= big;
          xsq_r   <= ax[MAG_W-1:0] * ax[MAG_W-1:0];
          ysq_r   <= ay[MAG_W-1:0] * ay[MAG_W-1:0];
          xy_r    <= ax[MAG_W-1:0] * ay[MAG_W-1:0];
          state_r <= S_ADD;
        end
        S_ADD: begin
          if (escaped) begin
            out_valid_r                <= 1'b1;
            out_data_r.iteration_count <= count_r;
            out_data_r.inside_set      <= (count_r == max_iterations);
            out_data_r.out_col         <= col_r;
            out_data_r.out_row         <= row_r;
            state_r                    <= S_IDLE;
          end else begin
            x_r     <= x_new;
            y_r     <= y_new;
            count_r <= count_inc;
            if (count_inc == max_iterations) begin
              out_valid_r                <= 1'b1;
              out_data_r.iteration_count <= count_inc;
              out_data_r.inside_set      <= 1'b1;
              out_data_r.out_col         <= col_r;
              out_data_r.out_row         <= row_r;
              state_r                    <= S_IDLE;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/burning_ship_escape_time.sv
// ----------------------------------------------------------------------------
// Burning Ship escape-time engine
// Computes the escape count of one Q6.26 point per word and echoes its pixel.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; up to two words wait in
// the input queue while one is iterated. The engine takes a point from the
// queue, then runs each iteration through the multiplier stage followed by
// the escape test and update. A point stops when it escapes or when its count
// reaches the limit; a zero limit needs no iteration. The result appears on
// out_data for exactly one cycle with out_valid high and must be captured
// then. The limit register is written through cfg_valid and cfg_data. The
// user must write it only while the block is idle; the block itself does
// not enforce this.
module burning_ship_escape_time import bse_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_word_t           in_data,
  output logic               out_valid,
  output out_word_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  logic [COUNT_W-1:0] max_iter_r;
  queue_head_t        head;
  logic               pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= MAX_ITER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_iter_r <= cfg_data;
    end
  end

  bse_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .max_iterations (max_iter_r),
    .head           (head),
    .pop            (pop)
  );

  bse_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .pop            (pop),
    .max_iterations (max_iter_r),
    .out_valid      (out_valid),
    .out_data       (out_data)
  );

endmodule

FILE: hw/rtl/bse_checker.sv
// ----------------------------------------------------------------------------
// Burning Ship port checker
// Tracks the limit and the words in flight from the ports and checks results.
// ----------------------------------------------------------------------------
module bse_checker import bse_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input out_word_t          out_data,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [COUNT_W-1:0] cfg_data
);

  logic [COUNT_W-1:0] limit_r;
  logic [2:0]         pend_r;
  logic               acc;

  assign acc = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= MAX_ITER_RESET;
      pend_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      if (acc && !out_valid) begin
        pend_r <= pend_r + 1'b1;
      end else if (out_valid && !acc) begin
        pend_r <= pend_r - 1'b1;
      end
    end
  end

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("Result word without an outstanding input word.");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'(QUEUE_DEPTH + 1))
    else $error("More words in flight than the block can hold.");

  a_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.inside_set |-> out_data.iteration_count == limit_r)
    else $error("Inside flag set with a count other than the limit.");

  a_escaped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.inside_set |-> out_data.iteration_count < limit_r)
    else $error("Escaped point with a count at or beyond the limit.");

endmodule

bind burning_ship_escape_time bse_checker u_bse_checker (.*);

FILE: test/burning_ship_escape_time_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Burning Ship escape-time engine testbench
// Sends Q6.26 points in random bursts, predicts each escape count, inside flag
// and pixel echo, and compares every result word against the oldest
// prediction. Covers the reset limit, a zero limit, the limit extremes and a
// long random sweep over points that mostly lie near the set.
// ----------------------------------------------------------------------------
module burning_ship_escape_time_tb;
  import bse_pkg::*;

  localparam int Q_ONE = 1 << FRAC_BITS;
  localparam logic [COUNT_W-1:0] LIMIT_AFTER_RESET = 12'd30;
  localparam logic [COUNT_W-1:0] LIMIT_TOP = 12'd4095;
  localparam logic [63:0] ESCAPE_MAG = 64'd2 << FRAC_BITS;
  localparam logic [63:0] ESCAPE_NORM = 64'd4 << (2 * FRAC_BITS);

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_word_t           in_data;
  logic               out_valid;
  out_word_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data;

  out_word_t          expected_escapes[$];
  logic [COUNT_W-1:0] iteration_limit;
  int                 mismatch_count;
  int                 burst_left;

  burning_ship_escape_time dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic out_word_t predict_escape(input in_word_t w,
                                               input logic [COUNT_W-1:0] limit);
    logic signed [63:0] zx, zy, c_re, c_im;
    logic [63:0]        ax, ay, xsq, ysq, cross_term;
    int                 count;
    bit                 escaped;
    out_word_t          r;
    c_re = {{32{w.point_real[POINT_W-1]}}, w.point_real};
    c_im = {{32{w.point_imag[POINT_W-1]}}, w.point_imag};
    zx = '0;
    zy = '0;
    count = 0;
    escaped = 1'b0;
    while (count < int'(limit) && !escaped) begin
      ax = zx[63] ? -zx : zx;
      ay = zy[63] ? -zy : zy;
      if (ax >= ESCAPE_MAG || ay >= ESCAPE_MAG) begin
        escaped = 1'b1;
      end else begin
        xsq = ax * ax;
        ysq = ay * ay;
        if (xsq + ysq >= ESCAPE_NORM) begin
          escaped = 1'b1;
        end else begin
          cross_term = (64'd2 * ax * ay) >> FRAC_BITS;
          xsq = xsq >> FRAC_BITS;
          ysq = ysq >> FRAC_BITS;
          zx = $signed(xsq) - $signed(ysq) + c_re;
          zy = $signed(cross_term) + c_im;
          count++;
        end
      end
    end
    r.iteration_count = COUNT_W'(count);
    r.inside_set = (count == int'(limit));
    r.out_col = w.pixel_col;
    r.out_row = w.pixel_row;
    return r;
  endfunction

  function automatic in_word_t make_point(input int re, input int im,
                                          input int col, input int row);
    in_word_t w;
    w.point_real = re;
    w.point_imag = im;
    w.pixel_col = PIXEL_W'(col);
    w.pixel_row = PIXEL_W'(row);
    return w;
  endfunction

  function automatic int edge_value();
    case ($urandom_range(0, 8))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 0;
      3: return 2 * Q_ONE;
      4: return -2 * Q_ONE;
      5: return 2 * Q_ONE - 1;
      6: return -2 * Q_ONE + 1;
      7: return 1;
      default: return -1;
    endcase
  endfunction

  function automatic in_word_t random_point();
    int re, im, pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      re = int'($urandom_range(0, 3 * Q_ONE - 1)) - 2 * Q_ONE;
      im = int'($urandom_range(0, 3 * Q_ONE - 1)) - 2 * Q_ONE;
    end else if (pick < 65) begin
      re = int'($urandom_range(0, Q_ONE / 8)) - (Q_ONE * 7 / 4) - Q_ONE / 16;
      im = int'($urandom_range(0, Q_ONE / 8)) - Q_ONE / 16;
    end else if (pick < 78) begin
      re = int'($urandom_range(0, Q_ONE)) - (Q_ONE * 3 / 5);
      im = -int'($urandom_range(0, Q_ONE));
    end else if (pick < 92) begin
      re = $urandom;
      im = $urandom;
    end else begin
      re = edge_value();
      im = edge_value();
    end
    return make_point(re, im, $urandom_range(0, 1023), $urandom_range(0, 1023));
  endfunction

  task automatic send_point(input in_word_t w);
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    expected_escapes.push_back(predict_escape(w, iteration_limit));
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 6);
    end
  endtask

  task automatic set_iteration_limit(input logic [COUNT_W-1:0] limit);
    start <= 1'b0;
    while (expected_escapes.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= limit;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    iteration_limit = limit;
  endtask

  task automatic test_reset_limit();
    send_point(make_point(0, 0, 0, 0));
    send_point(make_point(-Q_ONE * 7 / 4, -Q_ONE * 3 / 100, 1023, 1023));
    pace_sender();
    send_point(make_point(-Q_ONE / 2, -Q_ONE / 2, 0, 1023));
    send_point(make_point(Q_ONE, Q_ONE, 1023, 0));
  endtask

  task automatic test_field_extremes();
    send_point(make_point(32'h7fff_ffff, 32'h7fff_ffff, 682, 341));
    send_point(make_point(32'h8000_0000, 32'h8000_0000, 341, 682));
    send_point(make_point(-2 * Q_ONE, 0, 1, 2));
    send_point(make_point(2 * Q_ONE - 1, 0, 3, 4));
    pace_sender();
    send_point(make_point(0, -2 * Q_ONE, 5, 6));
    send_point(make_point(0, 2 * Q_ONE - 1, 7, 8));
    send_point(make_point(1, -1, 9, 10));
    send_point(make_point(32'h5555_5555, 32'haaaa_aaaa, 1022, 513));
  endtask

  task automatic test_zero_limit();
    set_iteration_limit('0);
    send_point(make_point(0, 0, 0, 0));
    send_point(make_point(32'h7fff_ffff, 32'h8000_0000, 1023, 1023));
    send_point(random_point());
  endtask

  task automatic test_limit_extremes();
    set_iteration_limit(12'd1);
    send_point(make_point(0, 0, 100, 200));
    send_point(make_point(-2 * Q_ONE, 0, 300, 400));
    send_point(make_point(32'h7fff_ffff, 0, 500, 600));
    set_iteration_limit(LIMIT_TOP);
    send_point(make_point(0, 0, 700, 800));
    send_point(make_point(-Q_ONE * 7 / 4, -Q_ONE * 3 / 100, 900, 1000));
    send_point(make_point(Q_ONE / 4, Q_ONE / 4, 11, 12));
  endtask

  task automatic test_random_sweep();
    logic [COUNT_W-1:0] limits [8];
    int                 counts [8];
    limits = '{LIMIT_AFTER_RESET, 12'd1, 12'd0, 12'd64, 12'd0, 12'd17, LIMIT_TOP,
               LIMIT_AFTER_RESET};
    counts = '{240, 240, 240, 240, 240, 240, 12, 240};
    limits[4] = COUNT_W'($urandom_range(2, 100));
    for (int p = 0; p < 8; p++) begin
      set_iteration_limit(limits[p]);
      for (int i = 0; i < counts[p]; i++) begin
        send_point(random_point());
        pace_sender();
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid) begin
      if (expected_escapes.size() == 0) begin
        $error("unexpected result word: count %0d inside %0d col %0d row %0d",
               out_data.iteration_count, out_data.inside_set, out_data.out_col,
               out_data.out_row);
        mismatch_count++;
      end else begin
        want = expected_escapes.pop_front();
        if (out_data.iteration_count !== want.iteration_count) begin
          $error("iteration_count: expected %0d, got %0d", want.iteration_count,
                 out_data.iteration_count);
          mismatch_count++;
        end
        if (out_data.inside_set !== want.inside_set) begin
          $error("inside_set: expected %0d, got %0d", want.inside_set,
                 out_data.inside_set);
          mismatch_count++;
        end
        if (out_data.out_col !== want.out_col) begin
          $error("out_col: expected %0d, got %0d", want.out_col, out_data.out_col);
          mismatch_count++;
        end
        if (out_data.out_row !== want.out_row) begin
          $error("out_row: expected %0d, got %0d", want.out_row, out_data.out_row);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    iteration_limit = LIMIT_AFTER_RESET;
    mismatch_count = 0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_limit();
    test_field_extremes();
    test_zero_limit();
    test_limit_extremes();
    test_random_sweep();

    start <= 1'b0;
    while (expected_escapes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_escapes.size() != 0) begin
      $error("%0d result words never arrived", expected_escapes.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
